// ===== rtl/lad_pkg.sv =====
`default_nettype none

package lad_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int DATA_W      = 32;
    localparam int BYTE_W      = 8;

    // Signed mode shifts both int8 bytes by 128: index ^ 0x8080 (= +32896).
    localparam logic [ADDR_W-1:0] SIGNED_INDEX_OFFSET = ADDR_W'(32896);

    typedef enum logic {
        CMD_TABLE_WRITE = 1'b0,
        CMD_ACCUMULATE  = 1'b1
    } cmd_t;

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic signed [DATA_W-1:0] word_t;

    // Control of the lookup stage, handed to the accumulator.
    typedef struct packed {
        logic valid;
        logic last;
    } lookup_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/lad_table.sv =====
`default_nettype none

module lad_table (
    input  wire                 aclk,
    input  wire                 write_en,
    input  wire                 read_en,
    input  wire  lad_pkg::addr_t addr,
    input  wire  lad_pkg::word_t write_data,
    output lad_pkg::word_t      read_data
);
    import lad_pkg::*;

    word_t mem [TABLE_DEPTH];
    word_t read_data_reg;

    always_ff @(posedge aclk) begin
        if (write_en) begin
            mem[addr] <= write_data;
        end
    end

    // Read data registered; holds while the pipeline stalls.
    always_ff @(posedge aclk) begin
        if (read_en) begin
            read_data_reg <= mem[addr];
        end
    end

    assign read_data = read_data_reg;

endmodule

`default_nettype wire

// ===== rtl/lad_accum.sv =====
`default_nettype none

module lad_accum (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire  lad_pkg::lookup_ctrl_t ctrl,
    input  wire  lad_pkg::word_t      product,
    output logic                      stall,
    output logic                      m_valid,
    input  wire                       m_ready,
    output lad_pkg::word_t            m_dot_sum
);
    import lad_pkg::*;

    word_t sum_reg,     sum_next;
    word_t out_sum_reg;
    logic  out_valid_reg, out_valid_next;
    word_t total;
    logic  advance;

    assign total   = sum_reg + product;
    // A finishing pair needs the output register free or being drained.
    assign stall   = ctrl.valid && ctrl.last && out_valid_reg && !m_ready;
    assign advance = ctrl.valid && !stall;

    always_comb begin
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (advance) begin
            if (ctrl.last) begin
                sum_next       = '0;
                out_valid_next = 1'b1;
            end else begin
                sum_next = total;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ctrl.last) begin
            out_sum_reg <= total;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_dot_sum = out_sum_reg;

endmodule

`default_nettype wire

// ===== rtl/lut_approx_dot_product.sv =====
`default_nettype none

// Approximate dot-product engine built around a 65536 x 32-bit product table.
// Each input transfer is either a table write (s_cmd = 0: s_table_value is
// stored at s_table_index, no result) or an operand pair (s_cmd = 1: the
// product at index weight*256 + activation is added to a 32-bit wrapping
// running sum). With signed_operands = 1 (reset value) both bytes are taken
// as int8 shifted by 128, i.e. the index is XORed with 0x8080. A pair with
// s_last_pair = 1 produces one result transfer carrying the sum including
// that pair, and the sum restarts from zero. Table entries must be written
// before they are read. Throughput is one transfer per cycle while no stall
// is asserted. The last pair passes through the registered table read, then
// the add into the output register, before m_valid rises. The only stall is
// a finishing pair meeting a full output register that the consumer is not
// draining. A table write followed right away by a read of the same entry is
// safe: the write lands before the read samples it. Configuration writes
// (cfg_data bit 0) are always accepted and apply to the next operand pair.

module lut_approx_dot_product (
    input  wire                  aclk,
    input  wire                  aresetn,
    // configuration
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire                  cfg_data,
    // input items
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire                  s_cmd,
    input  wire  [15:0]          s_table_index,
    input  wire  signed [31:0]   s_table_value,
    input  wire  [7:0]           s_weight_operand,
    input  wire  [7:0]           s_activation_operand,
    input  wire                  s_last_pair,
    // results
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic signed [31:0]   m_dot_sum
);
    import lad_pkg::*;

    logic         signed_operands_reg;
    logic         accept;
    logic         is_pair;
    logic         stall;
    addr_t        pair_index;
    addr_t        table_addr;
    word_t        product;
    word_t        dot_sum;
    lookup_ctrl_t ctrl_reg, ctrl_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_operands_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            signed_operands_reg <= cfg_data;
        end
    end

    assign s_ready = !stall;
    assign accept  = s_valid && s_ready;
    assign is_pair = (cmd_t'(s_cmd) == CMD_ACCUMULATE);

    // weight byte high, activation byte low; signed mode recenters both
    assign pair_index = {s_weight_operand, s_activation_operand}
                        ^ (signed_operands_reg ? SIGNED_INDEX_OFFSET : '0);
    assign table_addr = is_pair ? pair_index : s_table_index;

    lad_table u_table (
        .aclk       (aclk),
        .write_en   (accept && !is_pair),
        .read_en    (accept && is_pair),
        .addr       (table_addr),
        .write_data (s_table_value),
        .read_data  (product)
    );

    // lookup stage control: follows the registered read data
    always_comb begin
        ctrl_next = ctrl_reg;
        if (!stall) begin
            ctrl_next.valid = accept && is_pair;
            ctrl_next.last  = s_last_pair;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl_next;
        end
    end

    lad_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl_reg),
        .product   (product),
        .stall     (stall),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_dot_sum (dot_sum)
    );

    assign m_dot_sum = dot_sum;

endmodule

`default_nettype wire
